>>> rtl/best_fit_bin_packer_unit_defines.svh
// assertion macros used by the checker file
`ifndef BEST_FIT_BIN_PACKER_UNIT_DEFINES_SVH
`define BEST_FIT_BIN_PACKER_UNIT_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define BFBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define BFBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bfbp_pkg.sv
package bfbp_pkg;

  // field widths of the channels
  localparam int ITEM_SIZE_W  = 16;
  localparam int BIN_INDEX_W  = 6;
  localparam int SLOT_INDEX_W = 4;
  localparam int SPACE_W      = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CAP_W      = 16;
  localparam int BINS_W     = 7;
  localparam int SLOTS_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_BIN = 2'd2;

  localparam logic [CAP_W-1:0]   CAP_RST   = 16'd1000;
  localparam logic [BINS_W-1:0]  BINS_RST  = 7'd64;
  localparam logic [SLOTS_W-1:0] SLOTS_RST = 5'd16;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // control from the sequencer to the fit unit
  typedef struct packed {
    logic clear;
    logic eval;
  } fit_ctl_t;

endpackage

>>> rtl/bfbp_if.sv
// item channel
interface bfbp_item_if;
  logic                              valid;
  logic                              ready;
  logic [bfbp_pkg::ITEM_SIZE_W-1:0]  item_size;

  modport source (output valid, output item_size, input ready);
  modport sink   (input valid, input item_size, output ready);
endinterface

// result channel
interface bfbp_result_if;
  logic                              valid;
  logic                              ready;
  logic                              placed;
  logic [bfbp_pkg::BIN_INDEX_W-1:0]  bin_index;
  logic [bfbp_pkg::SLOT_INDEX_W-1:0] slot_index;
  logic [bfbp_pkg::SPACE_W-1:0]      space_after;

  modport source (output valid, output placed, output bin_index, output slot_index,
                  output space_after, input ready);
  modport sink   (input valid, input placed, input bin_index, input slot_index,
                  input space_after, output ready);
endinterface

// configuration write channel
interface bfbp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bfbp_pkg::CFG_IDX_W-1:0]  index;
  logic [bfbp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/bfbp_ram.sv
module bfbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bfbp_fit_unit.sv
module bfbp_fit_unit #(
  parameter int IDX_W     = 6,
  parameter int SIZE_BITS = 16,
  parameter int FILL_W    = 5,
  parameter int SL_W      = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bfbp_pkg::fit_ctl_t   ctl_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  logic [SIZE_BITS-1:0] used_i,
  input  logic [FILL_W-1:0]    fill_i,
  input  logic [SIZE_BITS-1:0] cap_i,
  input  logic [SIZE_BITS-1:0] size_i,
  input  logic [SL_W-1:0]      slots_i,
  output logic                 found_o,
  output logic [IDX_W-1:0]     best_idx_o,
  output logic [SIZE_BITS-1:0] best_space_o,
  output logic [SIZE_BITS-1:0] best_used_o,
  output logic [FILL_W-1:0]    best_fill_o
);

  logic                 found_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [SIZE_BITS-1:0] best_space_q;
  logic [SIZE_BITS-1:0] best_used_q;
  logic [FILL_W-1:0]    best_fill_q;
  logic [SIZE_BITS-1:0] free_space;
  logic                 fits;
  logic                 take;

  // free space of the bin, zero once used reaches capacity
  assign free_space = (used_i >= cap_i) ? '0 : (cap_i - used_i);
  assign fits       = (free_space >= size_i) && (SL_W'(fill_i) < slots_i);
  // strictly tighter keeps the lowest index on ties
  assign take       = ctl_i.eval && fits && (!found_q || (free_space < best_space_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  // best candidate so far
  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q   <= idx_i;
      best_space_q <= free_space;
      best_used_q  <= used_i;
      best_fill_q  <= fill_i;
    end
  end

  assign found_o      = found_q;
  assign best_idx_o   = best_idx_q;
  assign best_space_o = best_space_q;
  assign best_used_o  = best_used_q;
  assign best_fill_o  = best_fill_q;

endmodule

>>> rtl/best_fit_bin_packer_unit.sv
// Best-fit bin packer.
// item_i takes one item size per transaction; result_o returns placed, bin,
// slot and the space left in that bin; cfg_i writes the bin capacity
// (index 0), bins_in_use (index 1) and slots_per_bin (index 2), and is always ready.
// Each item walks the per-bin table once, one bin per cycle through the
// single read port of the table memory and one shared fit compare unit.
// The walk covers the bins in use, capped at NUM_BINS; the next item is
// accepted only once the finish state has loaded the result. A zero size
// skips the walk and goes straight to the finish state.
// After reset the table is swept to zero, one bin per cycle, over all
// NUM_BINS entries; item_i is not ready during the sweep, cfg_i works throughout.
// The result sits in an output register, so the next item is accepted while
// an earlier result waits; if a finished result finds the register still
// full because result_o is stalled, the block holds that result and the
// table update until the register frees.
module best_fit_bin_packer_unit #(
  parameter int NUM_BINS  = 64,
  parameter int MAX_SLOTS = 16,
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bfbp_item_if.sink            item_i,
  bfbp_result_if.source        result_o,
  bfbp_cfg_if.sink             cfg_i
);

  localparam int IDX_W   = $clog2(NUM_BINS);
  localparam int CNT_W   = $clog2(NUM_BINS + 1);
  localparam int NB_W    = (CNT_W > bfbp_pkg::BINS_W) ? CNT_W : bfbp_pkg::BINS_W;
  localparam int FILL_W  = $clog2(MAX_SLOTS + 1);
  localparam int SL_W    = (FILL_W > bfbp_pkg::SLOTS_W) ? FILL_W : bfbp_pkg::SLOTS_W;
  localparam int ENTRY_W = FILL_W + SIZE_BITS;

  // configuration registers
  logic [bfbp_pkg::CAP_W-1:0]   cap_q;
  logic [bfbp_pkg::BINS_W-1:0]  bins_q;
  logic [bfbp_pkg::SLOTS_W-1:0] slots_q;

  // sequencer state
  bfbp_pkg::state_e     state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic [SIZE_BITS-1:0] size_q, size_d;

  // output register
  logic                              out_vld_q, out_vld_d;
  logic                              placed_q, placed_d;
  logic [bfbp_pkg::BIN_INDEX_W-1:0]  bin_q, bin_d;
  logic [bfbp_pkg::SLOT_INDEX_W-1:0] slot_q, slot_d;
  logic [bfbp_pkg::SPACE_W-1:0]      space_q, space_d;
  logic                              out_load;

  // memory and fit unit hookup
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  bfbp_pkg::fit_ctl_t   fit_ctl;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] best_space;
  logic [SIZE_BITS-1:0] best_used;
  logic [FILL_W-1:0]    best_fill;

  // effective limits
  logic [NB_W-1:0]      nb_eff;
  logic [SL_W-1:0]      ns_eff;
  logic [SIZE_BITS-1:0] cap_eff;
  logic [SIZE_BITS-1:0] in_size;

  assign nb_eff  = (NB_W'(bins_q) > NB_W'(NUM_BINS)) ? NB_W'(NUM_BINS) : NB_W'(bins_q);
  assign ns_eff  = (SL_W'(slots_q) > SL_W'(MAX_SLOTS)) ? SL_W'(MAX_SLOTS) : SL_W'(slots_q);
  assign cap_eff = SIZE_BITS'(cap_q);
  assign in_size = SIZE_BITS'(item_i.item_size);

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= bfbp_pkg::CAP_RST;
      bins_q  <= bfbp_pkg::BINS_RST;
      slots_q <= bfbp_pkg::SLOTS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bfbp_pkg::REG_CAPACITY:      cap_q   <= cfg_i.data[bfbp_pkg::CAP_W-1:0];
        bfbp_pkg::REG_BINS_IN_USE:   bins_q  <= cfg_i.data[bfbp_pkg::BINS_W-1:0];
        bfbp_pkg::REG_SLOTS_PER_BIN: slots_q <= cfg_i.data[bfbp_pkg::SLOTS_W-1:0];
        default: ;
      endcase
    end
  end

  // per-bin table: slot count over used space
  bfbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BINS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared fit compare unit
  bfbp_fit_unit #(
    .IDX_W     (IDX_W),
    .SIZE_BITS (SIZE_BITS),
    .FILL_W    (FILL_W),
    .SL_W      (SL_W)
  ) u_fit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (fit_ctl),
    .idx_i        (cmp_idx_q),
    .used_i       (ram_rdata[SIZE_BITS-1:0]),
    .fill_i       (ram_rdata[ENTRY_W-1:SIZE_BITS]),
    .cap_i        (cap_eff),
    .size_i       (size_q),
    .slots_i      (ns_eff),
    .found_o      (found),
    .best_idx_o   (best_idx),
    .best_space_o (best_space),
    .best_used_o  (best_used),
    .best_fill_o  (best_fill)
  );

  // sequencer: clear sweep, accept, scan, finish
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    size_d       = size_q;
    ram_we       = 1'b0;
    ram_waddr    = best_idx;
    ram_wdata    = {FILL_W'(best_fill + 1'b1), SIZE_BITS'(best_used + size_q)};
    ram_raddr    = cnt_q[IDX_W-1:0];
    fit_ctl      = '0;
    out_load     = 1'b0;
    item_i.ready = 1'b0;

    case (state_q)
      bfbp_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[IDX_W-1:0];
        ram_wdata = '0;
        if (cnt_q == CNT_W'(NUM_BINS - 1)) begin
          cnt_d   = '0;
          state_d = bfbp_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      bfbp_pkg::ST_IDLE: begin
        item_i.ready = 1'b1;
        if (item_i.valid) begin
          size_d        = in_size;
          fit_ctl.clear = 1'b1;
          cnt_d         = '0;
          state_d       = (in_size == '0) ? bfbp_pkg::ST_FINISH : bfbp_pkg::ST_SCAN;
        end
      end
      bfbp_pkg::ST_SCAN: begin
        fit_ctl.eval = cmp_vld_q;
        if (NB_W'(cnt_q) < nb_eff) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = cnt_q[IDX_W-1:0];
          cnt_d     = cnt_q + 1'b1;
        end else if (!cmp_vld_q) begin
          state_d = bfbp_pkg::ST_FINISH;
        end
      end
      bfbp_pkg::ST_FINISH: begin
        if (!out_vld_q || result_o.ready) begin
          out_load = 1'b1;
          ram_we   = found;
          state_d  = bfbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bfbp_pkg::ST_IDLE;
      end
    endcase
  end

  // output register contents
  always_comb begin
    placed_d = found;
    bin_d    = found ? bfbp_pkg::BIN_INDEX_W'(best_idx) : '0;
    slot_d   = found ? bfbp_pkg::SLOT_INDEX_W'(best_fill) : '0;
    space_d  = found ? bfbp_pkg::SPACE_W'(best_space - size_q) : '0;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (result_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bfbp_pkg::ST_CLEAR;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    size_q    <= size_d;
    if (out_load) begin
      placed_q <= placed_d;
      bin_q    <= bin_d;
      slot_q   <= slot_d;
      space_q  <= space_d;
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.placed      = placed_q;
  assign result_o.bin_index   = bin_q;
  assign result_o.slot_index  = slot_q;
  assign result_o.space_after = space_q;

endmodule

>>> rtl/bfbp_checker.sv
`include "best_fit_bin_packer_unit_defines.svh"

module bfbp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              item_valid,
  input logic                              item_ready,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic                              placed,
  input logic [bfbp_pkg::BIN_INDEX_W-1:0]  bin_index,
  input logic [bfbp_pkg::SLOT_INDEX_W-1:0] slot_index,
  input logic [bfbp_pkg::SPACE_W-1:0]      space_after
);

  // an unplaced item reports all-zero fields
  `BFBP_ASSERT(a_unplaced_zero, clk_i, rst_ni, (res_valid && !placed) |-> (bin_index == '0 && slot_index == '0 && space_after == '0), "unplaced result has nonzero fields")

  // the block is busy right after taking an item
  `BFBP_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, item_valid && item_ready, !item_ready, "item accepted while a scan is running")

  // a stalled result holds its value
  `BFBP_ASSERT_NEXT(a_result_hold, clk_i, rst_ni, res_valid && !res_ready, res_valid && $stable(placed) && $stable(bin_index) && $stable(slot_index) && $stable(space_after), "stalled result changed")

endmodule

bind best_fit_bin_packer_unit bfbp_checker u_bfbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .item_valid  (item_i.valid),
  .item_ready  (item_i.ready),
  .res_valid   (result_o.valid),
  .res_ready   (result_o.ready),
  .placed      (result_o.placed),
  .bin_index   (result_o.bin_index),
  .slot_index  (result_o.slot_index),
  .space_after (result_o.space_after)
);
